// ----- rtl/core/osen_pkg.sv -----
package osen_pkg;

    localparam int STACK_DEPTH = 512;
    localparam int WORD_WIDTH  = 32;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int CW          = $clog2(STACK_DEPTH + 1);
    localparam int KW          = ((WORD_WIDTH > CW) ? WORD_WIDTH : CW) + 2;
    localparam int MODE_W      = 5;
    localparam int VALUE_W     = 32;
    localparam int LEVEL_W     = 10;

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef logic [AW-1:0]                t_addr;
    typedef logic [CW-1:0]                t_cnt;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH     = 5'd0,
        OP_POP      = 5'd1,
        OP_DUP      = 5'd2,
        OP_PDUP     = 5'd3,
        OP_OVER     = 5'd4,
        OP_SWAP     = 5'd5,
        OP_ROT      = 5'd6,
        OP_TUCK     = 5'd7,
        OP_NIP      = 5'd8,
        OP_PICK     = 5'd9,
        OP_PUT      = 5'd10,
        OP_POPN     = 5'd11,
        OP_DUPN     = 5'd12,
        OP_NDUP     = 5'd13,
        OP_LDUP     = 5'd14,
        OP_ROTATE   = 5'd15,
        OP_REVERSE  = 5'd16,
        OP_LREVERSE = 5'd17,
        OP_DEPTH    = 5'd18,
        OP_NOP      = 5'd31
    } t_op;

    typedef struct packed {
        t_op   op;
        t_word value;
    } t_item;

    typedef struct packed {
        t_status st;
        t_cnt    cnt;
        logic    wr_en;
        t_addr   wr_addr;
        t_word   wr_data;
        logic    cp_en;
        t_addr   cp_src;
        t_addr   cp_dst;
        t_cnt    cp_len;
        logic    cp_fix;
        logic    rt_en;
        t_addr   rt_a;
        t_addr   rt_b;
        logic    rt_up;
        logic    fl_en;
        t_addr   fl_lo;
        t_addr   fl_hi;
    } t_plan;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KWAIT,
        S_GO,
        S_WR,
        S_CP_RD,
        S_CP_WR,
        S_RT_RD0,
        S_RT_T,
        S_RT_CHK,
        S_RT_WR,
        S_RT_FIN,
        S_FL_RDLO,
        S_FL_RDHI,
        S_FL_WLO,
        S_FL_WHI,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } t_state;

    function automatic t_op classify(input logic [MODE_W-1:0] mode);
        t_op op;
        if (mode > MODE_W'(OP_DEPTH)) begin
            op = OP_NOP;
        end else begin
            op = t_op'(mode);
        end
        return op;
    endfunction

endpackage

// ----- rtl/core/osen_ram.sv -----
module osen_ram #(
    parameter int W = 32,
    parameter int D = 512
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/osen_front.sv -----
module osen_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [osen_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [osen_pkg::VALUE_W-1:0] i_value,
    output logic                              o_vld,
    output osen_pkg::t_item                   o_item,
    input  logic                              i_take
);

    osen_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            wr;
    logic            rd;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_q[r_rp];
    assign wr     = i_push && !o_full;
    assign rd     = i_take && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // classify the mode once, on the way in
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp].op    <= osen_pkg::classify(i_mode);
            r_q[r_wp].value <= osen_pkg::WORD_WIDTH'(i_value);
        end
    end

endmodule

// ----- rtl/core/osen_back.sv -----
module osen_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  osen_pkg::t_item    i_item,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output osen_pkg::t_word    o_top,
    output osen_pkg::t_cnt     o_lvl,
    output osen_pkg::t_status  o_st
);

    localparam int KW = osen_pkg::KW;

    osen_pkg::t_state  r_state, n_state;
    osen_pkg::t_cnt    r_n;
    osen_pkg::t_op     r_op;
    osen_pkg::t_word   r_val;
    osen_pkg::t_plan   r_plan;
    osen_pkg::t_plan   p;
    osen_pkg::t_addr   r_ptr;
    osen_pkg::t_addr   ptr_nb;
    osen_pkg::t_word   r_t;
    osen_pkg::t_word   r_t0;
    logic              r_out_vld;
    osen_pkg::t_word   r_top;
    osen_pkg::t_cnt    r_lvl;
    osen_pkg::t_status r_st;
    logic              out_load;

    logic              ram_we;
    osen_pkg::t_addr   ram_waddr;
    osen_pkg::t_word   ram_wdata;
    osen_pkg::t_addr   ram_raddr;
    logic [osen_pkg::WORD_WIDTH-1:0] ram_rdata;
    osen_pkg::t_word   rd_word;

    logic signed [KW-1:0] kx, nx, mx, m2x, dx;

    osen_ram #(
        .W (osen_pkg::WORD_WIDTH),
        .D (osen_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_word = ram_rdata;
    assign ptr_nb  = r_plan.rt_up ? r_ptr + 1'b1 : r_ptr - 1'b1;

    // plan the operation from the depth and the top word just read
    always_comb begin
        kx  = KW'(rd_word);
        nx  = KW'(r_n);
        mx  = nx - KW'(1);
        m2x = nx - KW'(2);
        dx  = KW'(osen_pkg::STACK_DEPTH);
        p         = '0;
        p.st      = osen_pkg::ST_OK;
        p.cnt     = r_n;
        p.wr_addr = osen_pkg::t_addr'(r_n);
        p.wr_data = r_val;
        p.cp_src  = osen_pkg::t_addr'(mx);
        p.cp_dst  = osen_pkg::t_addr'(nx);
        p.cp_len  = osen_pkg::t_cnt'(1);
        p.rt_up   = 1'b1;
        unique case (r_op)
            osen_pkg::OP_PUSH, osen_pkg::OP_DEPTH: begin
                if (nx >= dx) begin
                    p.st = osen_pkg::ST_OVER;
                end else begin
                    p.wr_en = 1'b1;
                    p.cnt   = r_n + 1'b1;
                    if (r_op == osen_pkg::OP_DEPTH) begin
                        p.wr_data = osen_pkg::WORD_WIDTH'(r_n);
                    end
                end
            end
            osen_pkg::OP_NOP: begin
            end
            default: begin
                if (r_n == '0) begin
                    p.st = osen_pkg::ST_UNDER;
                end else begin
                    unique case (r_op)
                        osen_pkg::OP_POP: begin
                            p.cnt = r_n - 1'b1;
                        end
                        osen_pkg::OP_DUP, osen_pkg::OP_PDUP: begin
                            priority if (r_op == osen_pkg::OP_PDUP && kx == '0) begin
                            end else if (nx >= dx) begin
                                p.st = osen_pkg::ST_OVER;
                            end else begin
                                p.cp_en = 1'b1;
                                p.cnt   = r_n + 1'b1;
                            end
                        end
                        osen_pkg::OP_LDUP: begin
                            priority if (kx < 0) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else if (kx + KW'(1) > dx - nx) begin
                                p.st = osen_pkg::ST_OVER;
                            end else begin
                                p.cp_en  = 1'b1;
                                p.cp_src = osen_pkg::t_addr'(mx - kx);
                                p.cp_len = osen_pkg::t_cnt'(kx + KW'(1));
                                p.cnt    = osen_pkg::t_cnt'(nx + kx + KW'(1));
                            end
                        end
                        osen_pkg::OP_OVER, osen_pkg::OP_SWAP, osen_pkg::OP_ROT,
                        osen_pkg::OP_TUCK, osen_pkg::OP_NIP: begin
                            priority if (nx < 2 || (r_op == osen_pkg::OP_ROT && nx < 3)) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else if ((r_op == osen_pkg::OP_OVER ||
                                          r_op == osen_pkg::OP_TUCK) && nx >= dx) begin
                                p.st = osen_pkg::ST_OVER;
                            end else begin
                                unique case (r_op)
                                    osen_pkg::OP_OVER: begin
                                        p.cp_en  = 1'b1;
                                        p.cp_src = osen_pkg::t_addr'(m2x);
                                        p.cnt    = r_n + 1'b1;
                                    end
                                    osen_pkg::OP_SWAP: begin
                                        p.fl_en = 1'b1;
                                        p.fl_lo = osen_pkg::t_addr'(m2x);
                                        p.fl_hi = osen_pkg::t_addr'(mx);
                                    end
                                    osen_pkg::OP_ROT: begin
                                        p.rt_en = 1'b1;
                                        p.rt_a  = osen_pkg::t_addr'(nx - KW'(3));
                                        p.rt_b  = osen_pkg::t_addr'(mx);
                                    end
                                    osen_pkg::OP_TUCK: begin
                                        // copy the top up, then sink it two places
                                        p.cp_en = 1'b1;
                                        p.rt_en = 1'b1;
                                        p.rt_up = 1'b0;
                                        p.rt_a  = osen_pkg::t_addr'(nx);
                                        p.rt_b  = osen_pkg::t_addr'(m2x);
                                        p.cnt   = r_n + 1'b1;
                                    end
                                    default: begin
                                        p.cp_en  = 1'b1;
                                        p.cp_dst = osen_pkg::t_addr'(m2x);
                                        p.cnt    = r_n - 1'b1;
                                    end
                                endcase
                            end
                        end
                        osen_pkg::OP_PICK: begin
                            priority if (kx < 1) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else begin
                                p.cp_en  = 1'b1;
                                p.cp_src = osen_pkg::t_addr'(mx - kx);
                                p.cp_dst = osen_pkg::t_addr'(mx);
                            end
                        end
                        osen_pkg::OP_PUT: begin
                            priority if (mx < 1) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else if (kx < 1) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > m2x) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else begin
                                p.cp_en  = 1'b1;
                                p.cp_src = osen_pkg::t_addr'(m2x);
                                p.cp_dst = osen_pkg::t_addr'(m2x - kx);
                                p.cnt    = osen_pkg::t_cnt'(m2x);
                            end
                        end
                        osen_pkg::OP_POPN: begin
                            priority if (kx < 0 || kx >= dx) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else begin
                                p.cnt = osen_pkg::t_cnt'(mx - kx);
                            end
                        end
                        osen_pkg::OP_DUPN: begin
                            priority if (kx < 0) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else if (kx > dx - mx) begin
                                p.st = osen_pkg::ST_OVER;
                            end else begin
                                p.cp_en  = 1'b1;
                                p.cp_src = osen_pkg::t_addr'(mx - kx);
                                p.cp_dst = osen_pkg::t_addr'(mx);
                                p.cp_len = osen_pkg::t_cnt'(kx);
                                p.cnt    = osen_pkg::t_cnt'(mx + kx);
                            end
                        end
                        osen_pkg::OP_NDUP: begin
                            priority if (mx < 1) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else if (kx <= 1) begin
                                p.cnt = osen_pkg::t_cnt'(mx);
                            end else if (kx - KW'(1) > dx - mx) begin
                                p.st = osen_pkg::ST_OVER;
                            end else begin
                                p.cp_en  = 1'b1;
                                p.cp_fix = 1'b1;
                                p.cp_src = osen_pkg::t_addr'(m2x);
                                p.cp_dst = osen_pkg::t_addr'(mx);
                                p.cp_len = osen_pkg::t_cnt'(kx - KW'(1));
                                p.cnt    = osen_pkg::t_cnt'(mx + kx - KW'(1));
                            end
                        end
                        osen_pkg::OP_ROTATE: begin
                            priority if (kx > mx || kx < -mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else begin
                                p.cnt = osen_pkg::t_cnt'(mx);
                                if (kx > 0) begin
                                    p.rt_en = 1'b1;
                                    p.rt_a  = osen_pkg::t_addr'(mx - kx);
                                    p.rt_b  = osen_pkg::t_addr'(m2x);
                                end else if (kx < 0) begin
                                    p.rt_en = 1'b1;
                                    p.rt_up = 1'b0;
                                    p.rt_a  = osen_pkg::t_addr'(m2x);
                                    p.rt_b  = osen_pkg::t_addr'(mx + kx);
                                end
                            end
                        end
                        default: begin
                            priority if (kx < 0) begin
                                p.st = osen_pkg::ST_BAD;
                            end else if (kx > mx) begin
                                p.st = osen_pkg::ST_UNDER;
                            end else begin
                                p.fl_en = (kx > 1);
                                p.fl_lo = osen_pkg::t_addr'(mx - kx);
                                p.fl_hi = osen_pkg::t_addr'(m2x);
                                p.cnt   = (r_op == osen_pkg::OP_LREVERSE) ? r_n
                                                                          : r_n - 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        o_take    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_plan.wr_addr;
        ram_wdata = rd_word;
        ram_raddr = osen_pkg::t_addr'(r_n - 1'b1);
        out_load  = 1'b0;
        unique case (r_state)
            osen_pkg::S_IDLE: begin
                if (i_vld) begin
                    o_take  = 1'b1;
                    n_state = osen_pkg::S_KWAIT;
                end
            end
            osen_pkg::S_KWAIT: begin
                n_state = osen_pkg::S_GO;
            end
            osen_pkg::S_GO: begin
                priority if (r_plan.wr_en) begin
                    n_state = osen_pkg::S_WR;
                end else if (r_plan.cp_en) begin
                    if (r_plan.cp_len != '0) begin
                        n_state = osen_pkg::S_CP_RD;
                    end
                end else if (r_plan.rt_en) begin
                    n_state = osen_pkg::S_RT_RD0;
                end else if (r_plan.fl_en) begin
                    if (r_plan.fl_lo < r_plan.fl_hi) begin
                        n_state = osen_pkg::S_FL_RDLO;
                    end
                end else begin
                    n_state = osen_pkg::S_TOP_RD;
                end
            end
            osen_pkg::S_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_plan.wr_data;
                n_state   = osen_pkg::S_GO;
            end
            osen_pkg::S_CP_RD: begin
                ram_raddr = r_plan.cp_src;
                n_state   = osen_pkg::S_CP_WR;
            end
            osen_pkg::S_CP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_plan.cp_dst;
                n_state   = osen_pkg::S_GO;
            end
            osen_pkg::S_RT_RD0: begin
                ram_raddr = r_plan.rt_a;
                n_state   = osen_pkg::S_RT_T;
            end
            osen_pkg::S_RT_T: begin
                n_state = osen_pkg::S_RT_CHK;
            end
            osen_pkg::S_RT_CHK: begin
                if (r_ptr == r_plan.rt_b) begin
                    n_state = osen_pkg::S_RT_FIN;
                end else begin
                    ram_raddr = ptr_nb;
                    n_state   = osen_pkg::S_RT_WR;
                end
            end
            osen_pkg::S_RT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                n_state   = osen_pkg::S_RT_CHK;
            end
            osen_pkg::S_RT_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = r_plan.rt_b;
                ram_wdata = r_t;
                n_state   = osen_pkg::S_GO;
            end
            osen_pkg::S_FL_RDLO: begin
                ram_raddr = r_plan.fl_lo;
                n_state   = osen_pkg::S_FL_RDHI;
            end
            osen_pkg::S_FL_RDHI: begin
                ram_raddr = r_plan.fl_hi;
                n_state   = osen_pkg::S_FL_WLO;
            end
            osen_pkg::S_FL_WLO: begin
                ram_we    = 1'b1;
                ram_waddr = r_plan.fl_lo;
                n_state   = osen_pkg::S_FL_WHI;
            end
            osen_pkg::S_FL_WHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_plan.fl_hi;
                ram_wdata = r_t0;
                n_state   = osen_pkg::S_GO;
            end
            osen_pkg::S_TOP_RD: begin
                n_state = osen_pkg::S_TOP_WAIT;
            end
            osen_pkg::S_TOP_WAIT, osen_pkg::S_OUT: begin
                // hold the read address on the top so the data stays put
                if (!r_out_vld || i_pop) begin
                    out_load = 1'b1;
                    n_state  = osen_pkg::S_IDLE;
                end else begin
                    n_state = osen_pkg::S_OUT;
                end
            end
            default: begin
                n_state = osen_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= osen_pkg::S_IDLE;
            r_n       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == osen_pkg::S_KWAIT) begin
                r_n <= p.cnt;
            end
            priority if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end else begin
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_op  <= i_item.op;
            r_val <= i_item.value;
        end
        if (out_load) begin
            r_top <= (r_n != '0) ? rd_word : '0;
            r_lvl <= r_n;
            r_st  <= r_plan.st;
        end
        unique case (r_state)
            osen_pkg::S_KWAIT: begin
                r_plan <= p;
            end
            osen_pkg::S_GO: begin
                // drop a finished loop so the next phase is picked
                priority if (r_plan.wr_en) begin
                end else if (r_plan.cp_en) begin
                    if (r_plan.cp_len == '0) begin
                        r_plan.cp_en <= 1'b0;
                    end
                end else if (r_plan.rt_en) begin
                end else if (r_plan.fl_en) begin
                    if (r_plan.fl_lo >= r_plan.fl_hi) begin
                        r_plan.fl_en <= 1'b0;
                    end
                end else begin
                end
            end
            osen_pkg::S_WR: begin
                r_plan.wr_en <= 1'b0;
            end
            osen_pkg::S_CP_WR: begin
                r_plan.cp_dst <= r_plan.cp_dst + 1'b1;
                r_plan.cp_len <= r_plan.cp_len - 1'b1;
                if (!r_plan.cp_fix) begin
                    r_plan.cp_src <= r_plan.cp_src + 1'b1;
                end
            end
            osen_pkg::S_RT_RD0: begin
                r_ptr <= r_plan.rt_a;
            end
            osen_pkg::S_RT_T: begin
                r_t <= rd_word;
            end
            osen_pkg::S_RT_WR: begin
                r_ptr <= ptr_nb;
            end
            osen_pkg::S_RT_FIN: begin
                r_plan.rt_en <= 1'b0;
            end
            osen_pkg::S_FL_RDHI: begin
                r_t0 <= rd_word;
            end
            osen_pkg::S_FL_WHI: begin
                r_plan.fl_lo <= r_plan.fl_lo + 1'b1;
                r_plan.fl_hi <= r_plan.fl_hi - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_empty = !r_out_vld;
    assign o_top   = r_top;
    assign o_lvl   = r_lvl;
    assign o_st    = r_st;

endmodule

// ----- rtl/core/operand_stack_engine_core.sv -----
// channel   direction  handshake              payload
// command   in         push / full            i_mode, i_value
// result    out        empty / pop            o_top_value, o_stack_level, o_status
//
// Each operation runs from take through top read and plan, the RAM moves, top
// re-read and the result register. Count operations loop over their entries:
// copy, rotate and swap loops move one entry or pair at a time, set by the
// single read port and single write port of the stack RAM.
// Reset clears the depth and both queues; stack contents are not cleared.
// A full result register stalls the sequencer; a two-word command queue
// keeps accepting while an operation runs.
module operand_stack_engine_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [osen_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [osen_pkg::VALUE_W-1:0]  i_value,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [osen_pkg::VALUE_W-1:0]  o_top_value,
    output logic [osen_pkg::LEVEL_W-1:0]         o_stack_level,
    output logic [1:0]                           o_status
);

    logic              vld;
    logic              take;
    osen_pkg::t_item   item;
    osen_pkg::t_word   top;
    osen_pkg::t_cnt    lvl;
    osen_pkg::t_status st;

    osen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_vld   (vld),
        .o_item  (item),
        .i_take  (take)
    );

    osen_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld),
        .i_item  (item),
        .o_take  (take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_top   (top),
        .o_lvl   (lvl),
        .o_st    (st)
    );

    assign o_top_value   = osen_pkg::VALUE_W'(top);
    assign o_stack_level = osen_pkg::LEVEL_W'(lvl);
    assign o_status      = st;

endmodule

// ----- rtl/core/osen_checker.sv -----
module osen_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                empty,
    input logic                                pop,
    input logic signed [osen_pkg::VALUE_W-1:0] o_top_value,
    input logic [osen_pkg::LEVEL_W-1:0]        o_stack_level,
    input logic [1:0]                          o_status
);

    logic [osen_pkg::LEVEL_W-1:0] r_last_lvl;

    // track the depth of the last word taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lvl <= '0;
        end else if (pop && !empty) begin
            r_last_lvl <= o_stack_level;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_top_value) && $stable(o_stack_level)
                              && $stable(o_status)))
        else $error("waiting word changed");

    a_error_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != osen_pkg::ST_OK) |-> (o_stack_level == r_last_lvl))
        else $error("depth moved on a failed word");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stack_level == '0) |-> (o_top_value == '0))
        else $error("nonzero top on an empty stack");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_stack_level <= osen_pkg::LEVEL_W'(osen_pkg::STACK_DEPTH)))
        else $error("depth beyond capacity");

endmodule

bind operand_stack_engine_core osen_checker u_osen_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_top_value   (o_top_value),
    .o_stack_level (o_stack_level),
    .o_status      (o_status)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import osen_pkg::*;

    localparam int DEPTH     = 512;
    localparam int LIMIT     = 5000000;

    typedef struct packed {
        logic [4:0]  mode;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [31:0] top;
        logic [9:0]  level;
        logic [1:0]  st;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [4:0]  i_mode = '0;
    logic signed [31:0] i_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [31:0] o_top_value;
    logic [9:0]  o_stack_level;
    logic [1:0]  o_status;

    t_cmd        cmd_q[$];
    t_res        result_q[$];
    logic [31:0] stk[DEPTH];
    int          depth_now;
    int          errors = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_off = 0;
    bit          calm = 0;
    bit          gen_done = 0;
    bit          pause_req = 0;

    operand_stack_engine_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void flip_range(int lo, int hi);
        logic [31:0] t;
        while (lo < hi) begin
            t = stk[lo]; stk[lo] = stk[hi]; stk[hi] = t;
            lo++; hi--;
        end
    endfunction

    // apply one operation to the shadow stack, return status
    function automatic t_status apply_op(logic [4:0] mode, logic [31:0] v);
        int n, m, k, j, i, lo;
        logic [31:0] t;
        n = depth_now;
        if (mode == OP_PUSH || mode == OP_DEPTH) begin
            if (n >= DEPTH) return ST_OVER;
            stk[n] = (mode == OP_PUSH) ? v : 32'(n);
            depth_now = n + 1;
            return ST_OK;
        end
        if (mode > OP_DEPTH) return ST_OK;
        if (n < 1) return ST_UNDER;
        case (mode)
            OP_POP: begin depth_now = n - 1; return ST_OK; end
            OP_DUP, OP_PDUP: begin
                if (mode == OP_PDUP && stk[n-1] == 0) return ST_OK;
                if (n >= DEPTH) return ST_OVER;
                stk[n] = stk[n-1]; depth_now = n + 1; return ST_OK;
            end
            OP_LDUP: begin
                k = $signed(stk[n-1]);
                if (k < 0) return ST_BAD;
                if (k > n - 1) return ST_UNDER;
                m = k + 1;
                if (m > DEPTH - n) return ST_OVER;
                for (i = 0; i < m; i++) stk[n+i] = stk[n-m+i];
                depth_now = n + m; return ST_OK;
            end
            default: ;
        endcase
        if (mode >= OP_OVER && mode <= OP_NIP) begin
            if (n < 2 || (mode == OP_ROT && n < 3)) return ST_UNDER;
            if ((mode == OP_OVER || mode == OP_TUCK) && n >= DEPTH) return ST_OVER;
            case (mode)
                OP_OVER: begin stk[n] = stk[n-2]; depth_now = n + 1; end
                OP_SWAP: flip_range(n - 2, n - 1);
                OP_ROT: begin
                    t = stk[n-3]; stk[n-3] = stk[n-2]; stk[n-2] = stk[n-1]; stk[n-1] = t;
                end
                OP_TUCK: begin
                    stk[n] = stk[n-1]; stk[n-1] = stk[n-2]; stk[n-2] = stk[n];
                    depth_now = n + 1;
                end
                default: begin stk[n-2] = stk[n-1]; depth_now = n - 1; end
            endcase
            return ST_OK;
        end
        // count is popped first
        k = $signed(stk[n-1]);
        m = n - 1;
        case (mode)
            OP_PICK: begin
                if (k < 1) return ST_BAD;
                if (k > m) return ST_UNDER;
                stk[m] = stk[m-k]; return ST_OK;
            end
            OP_PUT: begin
                if (m < 1) return ST_UNDER;
                m--;
                if (k < 1) return ST_BAD;
                if (k > m) return ST_UNDER;
                stk[m-k] = stk[m]; depth_now = m; return ST_OK;
            end
            OP_POPN: begin
                if (k < 0 || k >= DEPTH) return ST_BAD;
                if (k > m) return ST_UNDER;
                depth_now = m - k; return ST_OK;
            end
            OP_DUPN: begin
                if (k < 0) return ST_BAD;
                if (k > m) return ST_UNDER;
                if (k > DEPTH - m) return ST_OVER;
                for (i = 0; i < k; i++) stk[m+i] = stk[m-k+i];
                depth_now = m + k; return ST_OK;
            end
            OP_NDUP: begin
                if (m < 1) return ST_UNDER;
                if (k > 1) begin
                    j = k - 1;
                    if (j > DEPTH - m) return ST_OVER;
                    for (i = 0; i < j; i++) stk[m+i] = stk[m-1];
                    m += j;
                end
                depth_now = m; return ST_OK;
            end
            OP_ROTATE: begin
                if (k > m || k < -m) return ST_UNDER;
                if (k > 0) begin
                    i = m - k; t = stk[i];
                    for (; i + 1 < m; i++) stk[i] = stk[i+1];
                    stk[m-1] = t;
                end else if (k < 0) begin
                    lo = m + k; t = stk[m-1];
                    for (i = m - 1; i > lo; i--) stk[i] = stk[i-1];
                    stk[lo] = t;
                end
                depth_now = m; return ST_OK;
            end
            default: begin
                if (k < 0) return ST_BAD;
                if (k > m) return ST_UNDER;
                if (k > 1) flip_range(m - k, m - 1);
                depth_now = (mode == OP_LREVERSE) ? n : m;
                return ST_OK;
            end
        endcase
    endfunction

    function automatic t_res predict_word(t_cmd c);
        t_res r;
        r.st = apply_op(c.mode, c.value);
        r.level = 10'(depth_now);
        r.top = (depth_now > 0) ? stk[depth_now-1] : 32'd0;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (push && !full) begin
                result_q.push_back(predict_word({i_mode, i_value}));
                void'(cmd_q.pop_front());
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end else if (pause_req) begin
                push <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                if (!calm && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 19);
                    push <= 1'b0;
                end else begin
                    push <= 1'b1;
                    i_mode <= cmd_q[0].mode;
                    i_value <= cmd_q[0].value;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (result_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = result_q.pop_front();
                    if (o_top_value !== e.top) begin
                        $error("top_value exp %0d got %0d", $signed(e.top), o_top_value);
                        errors++;
                    end
                    if (o_stack_level !== e.level) begin
                        $error("stack_level exp %0d got %0d", e.level, o_stack_level);
                        errors++;
                    end
                    if (o_status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, o_status);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 12) == 0) begin
                recv_gap <= $urandom_range(1, 19);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("[operand_stack_engine_core] ERROR");
            $finish;
        end
    end

    task automatic add(logic [4:0] mode, logic [31:0] value);
        cmd_q.push_back('{mode: mode, value: value});
    endtask

    function automatic logic [31:0] small_count();
        return 32'($signed($urandom_range(0, 12)) - 3);
    endfunction

    initial begin
        int i, dice;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: underflow on empty, extremes, most operations, NOP and an unused mode
        add(OP_POP, 0);
        add(OP_SWAP, 0);
        add(OP_PUSH, 32'h7fffffff);
        add(OP_PUSH, 32'h80000000);
        add(OP_PUSH, 32'hffffffff);
        add(OP_PUSH, 0);
        add(OP_PDUP, 0);
        add(OP_DUP, 0);
        add(OP_POP, 0);
        add(OP_PDUP, 0);
        add(OP_POP, 0);
        add(OP_OVER, 0);
        add(OP_TUCK, 0);
        add(OP_ROT, 0);
        add(OP_NIP, 0);
        add(OP_DEPTH, 0);
        add(OP_PICK, 0);
        add(OP_PUSH, 32'hffffffff); add(OP_ROTATE, 0);
        add(OP_PUSH, 2); add(OP_LREVERSE, 0);
        add(OP_LDUP, 0);
        add(OP_PUSH, 0); add(OP_PUT, 0);
        add(5'd31, 32'h5a5a5a5a);
        add(5'd19, 0);

        // random: sequences with small counts, occasional wide values
        for (i = 0; i < 500; i++) begin
            dice = $urandom_range(0, 99);
            if (dice < 30) add(OP_PUSH, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9));
            else if (dice < 75) begin
                add(OP_PUSH, $urandom_range(0, 7) == 0 ? $urandom : small_count());
                add(5'($urandom_range(OP_PICK, OP_LREVERSE)), $urandom);
                i++;
            end else if (dice < 97) add(5'($urandom_range(OP_POP, OP_DEPTH)), $urandom);
            else add(5'($urandom_range(19, 31)), $urandom);
            // an extra push of one when the loop index hits 200
            if (i == 200) begin
                add(OP_PUSH, 1);
            end
        end
        // empty the stack, fill it to the top to hit overflow, then drain
        add(OP_DEPTH, 0); add(OP_POPN, 0);
        add(OP_PUSH, 9); add(OP_PUSH, 511); add(OP_NDUP, 0);
        add(OP_DEPTH, 0); add(OP_DEPTH, 0);
        add(OP_DUP, 0); add(OP_PUSH, 3); add(OP_LDUP, 0); add(OP_DUPN, 0);
        add(OP_POPN, 0);
        add(OP_POP, 0);
        gen_done = 1;

        wait (cmd_q.size() < 480);
        hold_off = 2000;
        wait (cmd_q.size() < 350);
        pause_req = 1;
        wait (result_q.size() == 0 && !push);
        pause_req = 0;
        wait (cmd_q.size() < 120);
        calm = 1;
        wait (cmd_q.size() == 0 && result_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("[operand_stack_engine_core] OK");
        end else begin
            $display("[operand_stack_engine_core] ERROR");
        end
        $finish;
    end

    initial depth_now = 0;
endmodule

// ----- sim.f -----
rtl/core/osen_pkg.sv
rtl/core/osen_ram.sv
rtl/core/osen_front.sv
rtl/core/osen_back.sv
rtl/core/operand_stack_engine_core.sv
rtl/core/osen_checker.sv
test/tb.sv
